[rtl/core/lpm_pkg.sv]
package lpm_pkg;

  // Field widths fixed by the item formats
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int PORT_W      = 8;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 48;
  localparam int TABLE_DEPTH = 256;

  // Longest prefix length; longer lengths are saturated to it
  localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

  // Request kinds carried on s_tuser; the fourth code is a no-op
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // One stored route
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] hop;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] prefix;
  } entry_t;

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic vld;
  } mctl_t;

  // Best route found so far
  typedef struct packed {
    logic              hit;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } best_t;

  // One result
  typedef struct packed {
    logic              table_full;
    logic [LEN_W-1:0]  match_length;
    logic [PORT_W-1:0] port_out;
    logic [ADDR_W-1:0] hop_out;
    logic              found;
  } result_t;

endpackage

[rtl/core/longest_prefix_match_lookup_core.sv]
// IPv4 longest-prefix-match route table.
// Requests arrive on the s_ stream; s_tuser carries the kind (load, lookup,
// clear; the fourth code does nothing). Every request gives exactly one
// result on the m_ stream. A load appends a route, or flags table_full when
// all TABLE_DEPTH entries are used; a clear empties the table.
// A load, clear or no-op result goes from the execute state into the output
// register once it is free. A lookup walks the stored routes through one
// shared compare unit, one route per cycle from a single-read-port table
// memory, then the drain and finish states; an empty table skips to finish.
// One request is worked on at a time: s_tready is high only while the
// sequencer is idle, so the table walk and m_tready set the request rate.
// The result sits in an output register; a new request is taken while it
// waits, and that request finishes once m_tready has freed the register.
// Reset empties the table and drops any pending result; no clearing pass is
// needed since only entries below the route count are read.
module longest_prefix_match_lookup_core #(
  parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // route_prefix[31:0], route_length[37:32], route_hop[69:38],
  // route_port[77:70], dest_addr[109:78], zero fill [111:110]
  input  logic [lpm_pkg::IN_DATA_W-1:0]   s_tdata,
  // kind[1:0]
  input  logic [1:0]                      s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // found[0], hop_out[32:1], port_out[40:33], match_length[46:41],
  // table_full[47]
  output logic [lpm_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  lpm_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] scan_idx, scan_idx_next;

  // Latched request
  lpm_pkg::kind_t              kind_q;
  logic [lpm_pkg::ADDR_W-1:0]  prefix_q;
  logic [lpm_pkg::LEN_W-1:0]   length_q;
  logic [lpm_pkg::ADDR_W-1:0]  hop_q;
  logic [lpm_pkg::PORT_W-1:0]  port_q;
  logic [lpm_pkg::ADDR_W-1:0]  dest_q;

  logic             wr_en;
  lpm_pkg::entry_t  wr_data;
  logic             rd_en;
  logic             rd_vld;
  lpm_pkg::entry_t  rd_data;
  lpm_pkg::mctl_t   mctl;
  lpm_pkg::best_t   best;

  lpm_pkg::result_t out_d;
  lpm_pkg::result_t res;
  logic             out_load;
  logic             out_free;
  logic             full;
  logic             last;

  assign s_tready = (state == lpm_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == DEPTH_CNT);
  assign last     = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);

  // Capture the request on accept
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind_q   <= lpm_pkg::kind_t'(s_tuser);
      prefix_q <= s_tdata[31:0];
      length_q <= s_tdata[37:32];
      hop_q    <= s_tdata[69:38];
      port_q   <= s_tdata[77:70];
      dest_q   <= s_tdata[109:78];
    end
  end

  // Saturate the length as the route is stored
  always_comb begin
    wr_data.prefix = prefix_q;
    wr_data.hop    = hop_q;
    wr_data.port   = port_q;
    wr_data.length = (length_q > lpm_pkg::LEN_MAX) ? lpm_pkg::LEN_MAX : length_q;
  end

  // Sequencer: next state and controls
  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_idx_next = scan_idx;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    mctl.clear    = 1'b0;
    mctl.vld      = rd_vld;
    out_load      = 1'b0;
    out_d         = '0;
    case (state)
      lpm_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          mctl.clear = 1'b1;
          state_next = lpm_pkg::ST_EXEC;
        end
      end
      lpm_pkg::ST_EXEC: begin
        case (kind_q)
          lpm_pkg::KIND_LOOKUP: begin
            scan_idx_next = '0;
            state_next = (count == '0) ? lpm_pkg::ST_FIN : lpm_pkg::ST_SCAN;
          end
          lpm_pkg::KIND_LOAD: begin
            if (out_free) begin
              out_load         = 1'b1;
              out_d.table_full = full;
              if (!full) begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
              state_next = lpm_pkg::ST_IDLE;
            end
          end
          lpm_pkg::KIND_CLEAR: begin
            if (out_free) begin
              out_load   = 1'b1;
              count_next = '0;
              state_next = lpm_pkg::ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = lpm_pkg::ST_IDLE;
            end
          end
        endcase
      end
      lpm_pkg::ST_SCAN: begin
        rd_en         = 1'b1;
        scan_idx_next = scan_idx + IDX_W'(1);
        if (last) begin
          state_next = lpm_pkg::ST_DRAIN;
        end
      end
      lpm_pkg::ST_DRAIN: begin
        state_next = lpm_pkg::ST_FIN;
      end
      lpm_pkg::ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (best.hit) begin
            out_d.found        = 1'b1;
            out_d.hop_out      = best.hop;
            out_d.port_out     = best.port;
            out_d.match_length = best.length;
          end
          state_next = lpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lpm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lpm_pkg::ST_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= out_d;
    end
  end

  assign m_tdata = res;

  lpm_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  lpm_match u_match (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mctl),
    .dest  (dest_q),
    .entry (rd_data),
    .best  (best)
  );

  // Route count never passes the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("route count above table depth");

  // A new result only comes out of the execute or finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $rose(m_tvalid) |->
      ($past(state) == lpm_pkg::ST_EXEC) || ($past(state) == lpm_pkg::ST_FIN))
    else $error("result raised outside execute or finish");

  // A load into a full table is flagged and stores nothing
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (state == lpm_pkg::ST_EXEC) && (kind_q == lpm_pkg::KIND_LOAD) && full && out_free
      |=> m_tvalid && res.table_full && $stable(count))
    else $error("full table load not flagged");

  // A lookup hit never reports a length above 32 and never flags table_full
  a_hit_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.found |-> (res.match_length <= lpm_pkg::LEN_MAX) && !res.table_full)
    else $error("bad lookup hit result");

endmodule

[rtl/core/lpm_table.sv]
module lpm_table #(
  parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH,
  parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  lpm_pkg::entry_t      wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output lpm_pkg::entry_t      rd_data
);

  lpm_pkg::entry_t mem [TABLE_DEPTH];

  // Write one route per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/lpm_match.sv]
module lpm_match (
  input  logic                        clk,
  input  logic                        rst,
  input  lpm_pkg::mctl_t              ctl,
  input  logic [lpm_pkg::ADDR_W-1:0]  dest,
  input  lpm_pkg::entry_t             entry,
  output lpm_pkg::best_t              best
);

  logic [lpm_pkg::ADDR_W-1:0] mask;
  logic [lpm_pkg::LEN_W-1:0]  shift;
  logic                       match;
  logic                       better;

  // Build the contiguous mask from the stored length (at most 32)
  always_comb begin
    shift = lpm_pkg::LEN_MAX - entry.length;
    if (entry.length == '0) begin
      mask = '0;
    end else begin
      mask = {lpm_pkg::ADDR_W{1'b1}} << shift;
    end
    match  = ((entry.prefix & mask) == (dest & mask));
    better = match && (!best.hit || (entry.length > best.length));
  end

  // Track the longest match; strict compare keeps the earliest on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      best.hit <= 1'b0;
    end else if (ctl.clear) begin
      best.hit    <= 1'b0;
      best.length <= '0;
    end else if (ctl.vld && better) begin
      best.hit    <= 1'b1;
      best.length <= entry.length;
      best.hop    <= entry.hop;
      best.port   <= entry.port;
    end
  end

endmodule

[test/longest_prefix_match_lookup_core_test.sv]
module longest_prefix_match_lookup_core_test;

  localparam int ADDR_W     = lpm_pkg::ADDR_W;
  localparam int LEN_W      = lpm_pkg::LEN_W;
  localparam int PORT_W     = lpm_pkg::PORT_W;
  localparam int IN_DATA_W  = lpm_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = lpm_pkg::OUT_DATA_W;
  localparam logic [LEN_W-1:0] LEN_MAX = lpm_pkg::LEN_MAX;

  // Fourth request code: the core answers with an all-zero result
  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int DEPTH = lpm_pkg::TABLE_DEPTH;
  // Longest lookup walks all DEPTH routes; leave margin after the last result
  localparam int DRAIN_CYCLES = DEPTH + 44;
  localparam int STALL_LIMIT = 20 * DEPTH;
  localparam int PHASE_REQS = 220;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] dest;
  } route_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;

  // Route table shadow used to predict lookups
  logic [ADDR_W-1:0] shadow_prefix [0:DEPTH-1];
  logic [LEN_W-1:0]  shadow_len [0:DEPTH-1];
  logic [ADDR_W-1:0] shadow_hop [0:DEPTH-1];
  logic [PORT_W-1:0] shadow_port [0:DEPTH-1];
  int                shadow_count = 0;

  // Routes as the generator sees them, to aim lookups at stored prefixes
  logic [ADDR_W-1:0] gen_prefix [$];
  logic [LEN_W-1:0]  gen_len [$];
  int                phase_reqs = 0;

  route_req_t        pending_reqs [$];
  route_req_t        cur_req;
  lpm_pkg::result_t  route_results [$];
  lpm_pkg::result_t  got_res;
  lpm_pkg::result_t  want_res;

  int send_idle_pct = 10;
  int recv_idle_pct = 77;
  int idle_cycles = 0;
  int errors = 0;
  int n_load = 0;
  int n_reject = 0;
  int n_hit = 0;
  int n_miss = 0;
  int n_clear = 0;
  int n_nop = 0;

  longest_prefix_match_lookup_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    if (len == '0) return '0;
    if (len >= LEN_MAX) return '1;
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  // Apply one request to the shadow table and return the result it must give
  function automatic lpm_pkg::result_t predict_route(input route_req_t req);
    lpm_pkg::result_t  res;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] mask;
    res = '0;
    case (req.kind)
      lpm_pkg::KIND_LOAD: begin
        if (shadow_count >= DEPTH) begin
          res.table_full = 1'b1;
          n_reject++;
        end else begin
          shadow_prefix[shadow_count] = req.prefix;
          shadow_len[shadow_count] = (req.len > LEN_MAX) ? LEN_MAX : req.len;
          shadow_hop[shadow_count] = req.hop;
          shadow_port[shadow_count] = req.port;
          shadow_count++;
          n_load++;
        end
      end
      lpm_pkg::KIND_LOOKUP: begin
        // Strictly longer wins, so the earliest route keeps a tie
        for (int i = 0; i < shadow_count; i++) begin
          len = shadow_len[i];
          mask = prefix_mask(len);
          if (((shadow_prefix[i] ^ req.dest) & mask) == '0 &&
              (!res.found || len > res.match_length)) begin
            res.found = 1'b1;
            res.hop_out = shadow_hop[i];
            res.port_out = shadow_port[i];
            res.match_length = len;
          end
        end
        if (res.found) n_hit++;
        else n_miss++;
      end
      lpm_pkg::KIND_CLEAR: begin
        shadow_count = 0;
        n_clear++;
      end
      default: n_nop++;
    endcase
    return res;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Queue a request and track what the table will hold
  task automatic push_req(input logic [1:0] kind, input logic [ADDR_W-1:0] prefix,
                          input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] hop,
                          input logic [PORT_W-1:0] port, input logic [ADDR_W-1:0] dest);
    route_req_t req;
    req = '{kind, prefix, len, hop, port, dest};
    pending_reqs.push_back(req);
    if (kind != KIND_NOP) phase_reqs++;
    if (kind == lpm_pkg::KIND_LOAD && gen_prefix.size() < DEPTH) begin
      gen_prefix.push_back(prefix);
      gen_len.push_back((len > LEN_MAX) ? LEN_MAX : len);
    end
    if (kind == lpm_pkg::KIND_CLEAR) begin
      gen_prefix.delete();
      gen_len.delete();
    end
  endtask

  task automatic push_noise(input logic [1:0] kind);
    push_req(kind, $urandom, LEN_W'($urandom_range(63, 0)), $urandom,
             PORT_W'($urandom_range(255, 0)), $urandom);
  endtask

  task automatic rand_load();
    int               idx;
    int               shared;
    int               pick;
    logic [LEN_W-1:0] len;
    logic [ADDR_W-1:0] prefix;
    pick = $urandom_range(99, 0);
    if (pick < 5) len = '0;
    else if (pick < 15) len = LEN_MAX;
    else if (pick < 20) len = LEN_W'($urandom_range(63, 33));
    else len = LEN_W'($urandom_range(31, 1));
    prefix = $urandom;
    if (gen_prefix.size() != 0) begin
      idx = $urandom_range(gen_prefix.size() - 1, 0);
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        // Same prefix and length as a stored route: the older one must win
        prefix = gen_prefix[idx] ^ ($urandom & ~prefix_mask(gen_len[idx]));
        len = gen_len[idx];
      end else if (pick < 60) begin
        // Share a random number of leading bits to build nested routes
        shared = $urandom_range(32, 0);
        prefix = (gen_prefix[idx] & prefix_mask(LEN_W'(shared))) |
                 ($urandom & ~prefix_mask(LEN_W'(shared)));
      end
    end
    push_req(lpm_pkg::KIND_LOAD, prefix, len, $urandom, PORT_W'($urandom_range(255, 0)),
             $urandom);
  endtask

  task automatic rand_lookup();
    int               idx;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] dest;
    dest = $urandom;
    if (gen_prefix.size() != 0 && $urandom_range(99, 0) < 75) begin
      idx = $urandom_range(gen_prefix.size() - 1, 0);
      mask = prefix_mask(gen_len[idx]);
      dest = (gen_prefix[idx] & mask) | ($urandom & ~mask);
    end
    push_req(lpm_pkg::KIND_LOOKUP, $urandom, LEN_W'($urandom_range(63, 0)), $urandom,
             PORT_W'($urandom_range(255, 0)), dest);
  endtask

  // Usually clear, fill with routes, then look them up; sprinkle no-ops
  task automatic rand_segment(input int loads, input int max_lookups);
    int lookups;
    if ($urandom_range(99, 0) < 80) push_noise(lpm_pkg::KIND_CLEAR);
    for (int i = 0; i < loads; i++) begin
      rand_load();
      if ($urandom_range(99, 0) < 10) rand_lookup();
      if ($urandom_range(99, 0) < 3) push_noise(KIND_NOP);
    end
    lookups = $urandom_range(max_lookups, 4);
    for (int i = 0; i < lookups; i++) begin
      rand_lookup();
      if ($urandom_range(99, 0) < 3) push_noise(KIND_NOP);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid || route_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit fill_table);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (fill_table) begin
      push_noise(lpm_pkg::KIND_CLEAR);
      rand_segment(DEPTH + 4, 30);
    end
    while (phase_reqs < PHASE_REQS)
      rand_segment($urandom_range(24, 1), 20);
    wait_drained();
    phase_reqs = 0;
  endtask

  // Drive requests from the pending queue; predict each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) route_results.push_back(predict_route(cur_req));
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          s_tuser <= cur_req.kind;
          s_tdata <= {2'b00, cur_req.dest, cur_req.port, cur_req.hop, cur_req.len,
                      cur_req.prefix};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res = lpm_pkg::result_t'(m_tdata);
        if (route_results.size() == 0) begin
          $display("%0t: result %h with no request outstanding", $time, m_tdata);
          errors++;
        end else begin
          want_res = route_results.pop_front();
          report_field("found", 32'(want_res.found), 32'(got_res.found));
          report_field("hop_out", want_res.hop_out, got_res.hop_out);
          report_field("port_out", 32'(want_res.port_out), 32'(got_res.port_out));
          report_field("match_length", 32'(want_res.match_length),
                       32'(got_res.match_length));
          report_field("table_full", 32'(want_res.table_full), 32'(got_res.table_full));
        end
      end
      m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // End the run when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("longest_prefix_match_lookup_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, default route, host route, saturation, ties
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'hC0A8_0177);
    push_req(lpm_pkg::KIND_LOAD, 32'h0000_0000, 6'd0, 32'h0A0A_0A0A, 8'd1, '1);
    push_req(lpm_pkg::KIND_LOOKUP, '1, '1, '1, '1, 32'hFFFF_FFFF);
    push_req(lpm_pkg::KIND_LOAD, 32'hC0A8_0100, 6'd24, 32'h1111_1111, 8'd2, '0);
    push_req(lpm_pkg::KIND_LOAD, 32'hC0A8_01FF, 6'd24, 32'h2222_2222, 8'd3, '0);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'hC0A8_0177);
    push_req(lpm_pkg::KIND_LOAD, 32'hFFFF_FFFF, LEN_MAX, 32'hFFFF_FFFF, 8'hFF, '1);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFE);
    push_req(lpm_pkg::KIND_LOAD, 32'h0A00_0000, 6'd63, 32'h0000_0000, 8'h00, '1);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'h0A00_0000);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'h0A00_0001);
    push_req(lpm_pkg::KIND_LOAD, 32'h8000_0000, 6'd1, 32'h8080_8080, 8'h80, '0);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'h8765_4321);
    push_req(KIND_NOP, '1, '1, '1, '1, '1);
    push_req(lpm_pkg::KIND_LOOKUP, '1, '1, '1, '1, 32'h0000_0000);
    push_req(lpm_pkg::KIND_CLEAR, '1, '1, '1, '1, '1);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'hC0A8_0177);
    push_req(lpm_pkg::KIND_LOAD, 32'h1234_5678, 6'd33, 32'h5555_5555, 8'h55, '0);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'h1234_5678);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'h1234_5679);
    push_req(lpm_pkg::KIND_LOAD, $urandom, 6'd0, $urandom, PORT_W'($urandom_range(255, 0)),
             $urandom);
    push_req(lpm_pkg::KIND_LOOKUP, '0, '0, '0, '0, 32'h0000_0000);

    run_phase(10, 77, 1'b0);
    run_phase(77, 10, 1'b1);
    run_phase(0, 0, 1'b0);

    // Let any stray result show up before judging
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("ran %0d loads (%0d refused on a full table), %0d lookups (%0d hit, %0d missed)",
             n_load + n_reject, n_reject, n_hit + n_miss, n_hit, n_miss);
    $display("plus %0d clears and %0d no-op requests; %0d errors", n_clear, n_nop, errors);
    if (errors == 0) begin
      $display("longest_prefix_match_lookup_core: match");
    end else begin
      $display("longest_prefix_match_lookup_core: mismatch");
    end
    $finish;
  end

endmodule
